FILE: src/k_nearest_neighbour_search_defines.svh
// Assertion macros used by the checker file.
`ifndef K_NEAREST_NEIGHBOUR_SEARCH_DEFINES_SVH
`define K_NEAREST_NEIGHBOUR_SEARCH_DEFINES_SVH
// Implication checked at every edge outside reset.
`define KNN_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KNN_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: src/knn_pkg.sv
// Package with sizes and helpers of the nearest-neighbour search block.
package knn_pkg;
  localparam int MaxCorpus     = 1024;
  localparam int MaxDims       = 16;
  localparam int MaxNeighbours = 16;

  localparam logic [1:0] CFG_DIMS  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_K     = 2'd2;

  localparam logic OP_CORPUS = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Word passed from the front to the back: one query coordinate.
  typedef struct packed {
    logic signed [15:0] coordinate;
    logic               last_coord;
  } knn_cmd_t;
endpackage

FILE: src/knn_if.sv
// Valid/ready channel interfaces of the block.
interface knn_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] coordinate;
  modport source (output valid, operation, coordinate, input ready);
  modport sink (input valid, operation, coordinate, output ready);
endinterface

interface knn_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  neighbour_rank;
  logic [9:0]  neighbour_index;
  logic [17:0] distance;
  logic        last;
  modport source (output valid, neighbour_rank, neighbour_index, distance, last, input ready);
  modport sink (input valid, neighbour_rank, neighbour_index, distance, last, output ready);
endinterface

interface knn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/knn_fifo.sv
// Short queue of query words between front and back.
module knn_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  knn_pkg::knn_cmd_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output knn_pkg::knn_cmd_t rd_data
);
  import knn_pkg::*;
  knn_cmd_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_data  = mem_r[rp_r];

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + 2'd1;
      if (rd_valid && rd_ready) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_valid && wr_ready} - {2'd0, rd_valid && rd_ready};
    end
  end
endmodule

FILE: src/knn_front.sv
// Front part: registers, corpus loading and query word classification.
module knn_front #(
  parameter int MAX_CORPUS = knn_pkg::MaxCorpus,
  parameter int MAX_DIMS   = knn_pkg::MaxDims,
  parameter int MAX_NEIGHBOURS = knn_pkg::MaxNeighbours,
  parameter int CAW = $clog2(MAX_CORPUS * MAX_DIMS),
  parameter int CNW = $clog2(MAX_CORPUS + 1),
  parameter int DW  = $clog2(MAX_DIMS + 1),
  parameter int KW  = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  knn_in_if.sink                   in_ch,
  knn_cfg_if.sink                  cfg_ch,
  input  logic                     back_idle,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output knn_pkg::knn_cmd_t        cmd_data,
  output logic                     q_restart,
  output logic                     cw_en,
  output logic [CAW-1:0]           cw_addr,
  output logic signed [15:0]       cw_data,
  output logic [DW-1:0]            dims,
  output logic [CNW-1:0]           count,
  output logic [KW-1:0]            kk
);
  import knn_pkg::*;
  logic [4:0]  dims_r, k_r;
  logic [10:0] count_r;
  logic [CAW:0] cwp_r;
  logic [DW-1:0] qwp_r, qwp_nxt;
  logic [CAW+1:0] limit;
  logic acc, is_q;

  // Saturate registers into their ranges.
  always_comb begin
    if (dims_r == 5'd0) dims = DW'(1);
    else if (32'(dims_r) > MAX_DIMS) dims = DW'(MAX_DIMS);
    else dims = DW'(dims_r);
    if (count_r == 11'd0) count = CNW'(1);
    else if (32'(count_r) > MAX_CORPUS) count = CNW'(MAX_CORPUS);
    else count = CNW'(count_r);
    if (k_r == 5'd0) kk = KW'(1);
    else if (32'(k_r) > MAX_NEIGHBOURS) kk = KW'(MAX_NEIGHBOURS);
    else kk = KW'(k_r);
    if (32'(kk) > 32'(count)) kk = KW'(count);
    limit = (CAW+2)'(count) * (CAW+2)'(dims);
  end

  assign is_q = in_ch.operation == OP_QUERY;
  assign in_ch.ready = is_q ? cmd_ready : back_idle;
  assign cfg_ch.ready = 1'b1;
  assign acc = in_ch.valid && in_ch.ready;

  // A dims write also drops the partial query held by the back part.
  assign q_restart = cfg_ch.valid && cfg_ch.ready && (cfg_ch.index == CFG_DIMS);

  always_comb begin
    qwp_nxt = (qwp_r >= dims) ? '0 : qwp_r;
    qwp_nxt = qwp_nxt + DW'(1);
  end
  assign cmd_valid = in_ch.valid && is_q;
  assign cmd_data.coordinate = in_ch.coordinate;
  assign cmd_data.last_coord = qwp_nxt >= dims;
  assign cw_en   = acc && !is_q && ({1'b0, cwp_r} < limit);
  assign cw_addr = cwp_r[CAW-1:0];
  assign cw_data = in_ch.coordinate;

  // Register file and write positions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 5'd1; count_r <= 11'd1024; k_r <= 5'd1;
      cwp_r <= '0; qwp_r <= '0;
    end else begin
      if (cw_en) cwp_r <= cwp_r + 1'b1;
      if (acc && is_q) qwp_r <= cmd_data.last_coord ? '0 : qwp_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_DIMS:  begin dims_r <= cfg_ch.data[4:0]; qwp_r <= '0; end
          CFG_COUNT: begin count_r <= cfg_ch.data; cwp_r <= '0; end
          CFG_K:     k_r <= cfg_ch.data[4:0];
          default:   ;
        endcase
      end
    end
  end
endmodule

FILE: src/knn_back.sv
// Back part: corpus scan, sorted best list and result output.
module knn_back #(
  parameter int MAX_CORPUS = knn_pkg::MaxCorpus,
  parameter int MAX_DIMS   = knn_pkg::MaxDims,
  parameter int MAX_NEIGHBOURS = knn_pkg::MaxNeighbours,
  parameter int CAW = $clog2(MAX_CORPUS * MAX_DIMS),
  parameter int CNW = $clog2(MAX_CORPUS + 1),
  parameter int DW  = $clog2(MAX_DIMS + 1),
  parameter int KW  = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  knn_pkg::knn_cmd_t  cmd_data,
  input  logic               q_restart,
  input  logic               cw_en,
  input  logic [CAW-1:0]     cw_addr,
  input  logic signed [15:0] cw_data,
  input  logic [DW-1:0]      dims,
  input  logic [CNW-1:0]     count,
  input  logic [KW-1:0]      kk,
  output logic               idle,
  knn_out_if.source          out_ch
);
  import knn_pkg::*;
  localparam int QIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int PW  = (MAX_CORPUS > 1) ? $clog2(MAX_CORPUS) : 1;
  localparam logic [2:0] S_COLLECT = 3'd0, S_RD = 3'd1, S_ACC = 3'd2, S_INS = 3'd3,
                         S_SQRT = 3'd4, S_OUT = 3'd5;

  logic signed [15:0] cmem [MAX_CORPUS * MAX_DIMS];
  logic signed [15:0] qst_r [MAX_DIMS];
  logic signed [15:0] crd_r;
  logic [QIW-1:0] qi_r;
  logic [2:0] st_r;
  logic [CNW-1:0] pt_r;
  logic [DW-1:0] dj_r;
  logic [CAW-1:0] ra_r;
  logic [36:0] sq_r, bd_r [MAX_NEIGHBOURS];
  logic [PW-1:0] bi_r [MAX_NEIGHBOURS];
  logic [KW-1:0] fil_r, oj_r;
  logic [NW:0] pos;
  logic signed [16:0] df;
  logic [16:0] ad;
  logic [33:0] prod;
  logic [36:0] rem_r, res_r;
  logic [5:0] sstep_r;
  logic [37:0] trial;
  logic ovalid_r;

  // Corpus memory, registered read.
  always_ff @(posedge clk) begin
    if (cw_en) cmem[cw_addr] <= cw_data;
    crd_r <= cmem[ra_r];
  end

  assign idle = (st_r == S_COLLECT) && !ovalid_r && !cmd_valid;
  assign cmd_ready = (st_r == S_COLLECT);

  always_comb begin
    df = 17'(crd_r) - 17'(qst_r[dj_r[QIW-1:0] - QIW'(1)]);
    ad = df[16] ? 17'(-df) : 17'(df);
    prod = 34'(ad) * 34'(ad);
    pos = (NW+1)'(fil_r);
    for (int i = MAX_NEIGHBOURS - 1; i >= 0; i--)
      if (i < 32'(fil_r) && bd_r[i] > sq_r) pos = (NW+1)'(i);
    trial = {1'b0, res_r} + (38'd1 << {sstep_r, 1'b0});
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.neighbour_rank = 4'(oj_r);
  assign out_ch.neighbour_index = 10'(bi_r[oj_r[NW-1:0]]);
  assign out_ch.distance = 18'(res_r);
  assign out_ch.last = (oj_r + KW'(1)) == fil_r;

  // Scan sequencer: one coordinate per cycle, then insertion, then sqrt per result.
  // The coordinate read at one address is paired with its query word in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) qst_r[qi_r] <= cmd_data.coordinate;
    if (!rst_n) begin
      st_r <= S_COLLECT; qi_r <= '0; ovalid_r <= 1'b0;
      fil_r <= '0; oj_r <= '0;
    end else begin
      case (st_r)
        S_COLLECT: if (q_restart) qi_r <= '0;
        else if (cmd_valid) begin
          qi_r <= cmd_data.last_coord ? '0 : qi_r + QIW'(1);
          if (cmd_data.last_coord) begin
            st_r <= S_RD; pt_r <= '0; ra_r <= '0; fil_r <= '0;
          end
        end
        S_RD: begin
          dj_r <= '0; sq_r <= '0; st_r <= S_ACC;
        end
        S_ACC: begin
          dj_r <= dj_r + DW'(1);
          if (dj_r != '0) sq_r <= sq_r + 37'(prod);
          if (dj_r == dims) st_r <= S_INS;
          else ra_r <= ra_r + CAW'(1);
        end
        S_INS: begin
          if (32'(pos) < 32'(kk)) begin
            for (int i = MAX_NEIGHBOURS - 1; i > 0; i--)
              if (i > 32'(pos) && i <= 32'(fil_r)) begin
                bd_r[i] <= bd_r[i-1]; bi_r[i] <= bi_r[i-1];
              end
            bd_r[pos[NW-1:0]] <= sq_r; bi_r[pos[NW-1:0]] <= PW'(pt_r);
            if (fil_r < kk) fil_r <= fil_r + KW'(1);
          end
          pt_r <= pt_r + CNW'(1);
          if (pt_r + CNW'(1) == count) begin
            st_r <= S_SQRT; oj_r <= '0; res_r <= '0;
            sstep_r <= 6'd18;
            rem_r <= (32'(pos) == 0) ? sq_r : bd_r[0];
          end else st_r <= S_RD;
        end
        S_SQRT: begin
          if (rem_r >= trial[36:0]) begin
            rem_r <= rem_r - trial[36:0];
            res_r <= (res_r >> 1) + (37'd1 << {sstep_r, 1'b0});
          end else res_r <= res_r >> 1;
          sstep_r <= sstep_r - 6'd1;
          if (sstep_r == 6'd0) begin st_r <= S_OUT; ovalid_r <= 1'b1; end
        end
        S_OUT: if (out_ch.ready) begin
          ovalid_r <= 1'b0;
          if (out_ch.last) st_r <= S_COLLECT;
          else begin
            oj_r <= oj_r + KW'(1); st_r <= S_SQRT; res_r <= '0; sstep_r <= 6'd18;
            rem_r <= bd_r[oj_r[NW-1:0] + NW'(1)];
          end
        end
        default: st_r <= S_COLLECT;
      endcase
    end
  end
endmodule

FILE: src/k_nearest_neighbour_search.sv
// Top level of the brute-force nearest-neighbour search block.
// Corpus words are written straight into corpus memory; query words go to a queue.
// After the last query word the back part scans the corpus, each entry read, summed
// and inserted, then computes each result by bit-serial square root and outputs it.
// The back part takes no new query word until all results of the last are output.
// Synchronous active-low reset clears control state and sets register defaults.
module k_nearest_neighbour_search #(
  parameter int MAX_CORPUS = knn_pkg::MaxCorpus,
  parameter int MAX_DIMS   = knn_pkg::MaxDims,
  parameter int MAX_NEIGHBOURS = knn_pkg::MaxNeighbours
) (
  input logic      clk,
  input logic      rst_n,
  knn_in_if.sink   in_ch,
  knn_out_if.source out_ch,
  knn_cfg_if.sink  cfg_ch
);
  import knn_pkg::*;
  localparam int CAW = $clog2(MAX_CORPUS * MAX_DIMS);
  localparam int CNW = $clog2(MAX_CORPUS + 1);
  localparam int DW  = $clog2(MAX_DIMS + 1);
  localparam int KW  = $clog2(MAX_NEIGHBOURS + 1);

  logic fv, fr, bv, br, cw_en, idle, q_restart;
  knn_cmd_t fd, bd;
  logic [CAW-1:0] cw_addr;
  logic signed [15:0] cw_data;
  logic [DW-1:0] dims;
  logic [CNW-1:0] count;
  logic [KW-1:0] kk;

  knn_front #(.MAX_CORPUS(MAX_CORPUS), .MAX_DIMS(MAX_DIMS), .MAX_NEIGHBOURS(MAX_NEIGHBOURS))
    u_front (.clk, .rst_n, .in_ch, .cfg_ch, .back_idle(idle && !bv), .cmd_valid(fv),
             .cmd_ready(fr), .cmd_data(fd), .q_restart, .cw_en, .cw_addr, .cw_data, .dims,
             .count, .kk);
  knn_fifo u_fifo (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
                   .rd_valid(bv), .rd_ready(br), .rd_data(bd));
  knn_back #(.MAX_CORPUS(MAX_CORPUS), .MAX_DIMS(MAX_DIMS), .MAX_NEIGHBOURS(MAX_NEIGHBOURS))
    u_back (.clk, .rst_n, .cmd_valid(bv), .cmd_ready(br), .cmd_data(bd), .q_restart, .cw_en,
            .cw_addr, .cw_data, .dims, .count, .kk, .idle, .out_ch);
endmodule

FILE: src/knn_checker.sv
// Port-level checker for the nearest-neighbour search block and its bind.
`include "k_nearest_neighbour_search_defines.svh"
module knn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_rank,
  input logic       out_last,
  input logic       cfg_ready
);
  `KNN_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `KNN_ASSERT_NXT(a_rank, clk, rst_n, out_valid && out_ready && !out_last, out_rank != 4'd0 || !out_valid)
  `KNN_ASSERT_IMP(a_cfg, clk, rst_n, 1'b1, cfg_ready)
endmodule

bind k_nearest_neighbour_search knn_checker u_chk (.clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rank(out_ch.neighbour_rank),
  .out_last(out_ch.last), .cfg_ready(cfg_ch.ready));
